FILE: rtl/mcsp_pkg.sv
`default_nettype none

package mcsp_pkg;

    // Field widths
    localparam int FUNC_W  = 1;
    localparam int CHAN_W  = 4;
    localparam int ANGLE_W = 8;
    localparam int PULSE_W = 8;
    localparam int PHASE_W = 10;
    localparam int PINS_W  = 10;
    localparam int PROD_W  = 2 * PULSE_W;

    // Stream widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // Item kinds carried on tuser
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_ANGLE = 1'b1;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_addr;
    localparam t_cfg_addr CFG_PERIOD_TOP = 2'd0;
    localparam t_cfg_addr CFG_PULSE_MIN  = 2'd1;
    localparam t_cfg_addr CFG_PULSE_MAX  = 2'd2;
    localparam t_cfg_addr CFG_CH_ENABLE  = 2'd3;
    localparam int        CFG_DATA_W     = 10;

    // Register reset values
    localparam logic [PHASE_W-1:0] PERIOD_TOP_RST = 10'd385;
    localparam logic [PULSE_W-1:0] PULSE_MIN_RST  = 8'd11;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RST  = 8'd48;
    localparam logic [PINS_W-1:0]  CH_ENABLE_RST  = 10'h3FF;

    // Angle scaling: x/180 = (x>>2)/45, and y/45 = (y*11651)>>19 for y < 74898
    localparam logic [ANGLE_W-1:0] ANGLE_FULL  = 8'd180;
    localparam int                 RECIP_W     = PROD_W - 2;
    localparam logic [RECIP_W-1:0] RECIP_45    = 14'd11651;
    localparam int                 RECIP_SHIFT = 19;

    // Load strobes for the two scaling stages
    typedef struct packed {
        logic load_a;
        logic load_b;
    } t_scale_ctl;

endpackage

`default_nettype wire

FILE: rtl/mcsp_angle_scale.sv
`default_nettype none

module mcsp_angle_scale (
    input  wire                          i_clk,
    input  mcsp_pkg::t_scale_ctl         i_ctl,
    input  wire [mcsp_pkg::ANGLE_W-1:0]  i_angle,
    input  wire [mcsp_pkg::PULSE_W-1:0]  i_pulse_min,
    input  wire [mcsp_pkg::PULSE_W-1:0]  i_pulse_max,
    output logic [mcsp_pkg::PULSE_W-1:0] o_width
);
    import mcsp_pkg::*;

    logic [ANGLE_W-1:0]          sat_angle;
    logic [PULSE_W-1:0]          span;
    logic [PROD_W-1:0]           n_prod;
    logic [PROD_W-1:0]           r_prod;
    logic [RECIP_W-1:0]          quarter;
    logic [2*RECIP_W-1:0]        scaled;
    logic [PULSE_W-1:0]          n_width;
    logic [PULSE_W-1:0]          r_width;

    // Stage A: saturate angle, clamp span, multiply
    always_comb begin
        sat_angle = (i_angle > ANGLE_FULL) ? ANGLE_FULL : i_angle;
        span      = (i_pulse_max > i_pulse_min) ? (i_pulse_max - i_pulse_min) : '0;
        n_prod    = PROD_W'(sat_angle) * PROD_W'(span);
    end

    // Stage B: divide by 180 through a reciprocal, add offset
    always_comb begin
        quarter = r_prod[PROD_W-1:2];
        scaled  = (2*RECIP_W)'(quarter) * (2*RECIP_W)'(RECIP_45);
        n_width = scaled[RECIP_SHIFT +: PULSE_W] + i_pulse_min;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_a) begin
            r_prod <= n_prod;
        end
        if (i_ctl.load_b) begin
            r_width <= n_width;
        end
    end

    assign o_width = r_width;

endmodule

`default_nettype wire

FILE: rtl/multi_channel_servo_pwm.sv
// Servo PWM generator: shared period counter, per-channel pulse widths.
// An input item is registered in stage A, then stage B, then the output register, which presents its result.
// Throughput: one item per cycle unless the output stalls; the three-stage pipeline
// (product, scale, state update) is in-order; a stage advances when the next frees up.
// Reset (i_rst_n low, synchronous): registers take their documented defaults,
// counter, pulse widths and pin levels clear, and the pipeline empties.
`default_nettype none

module multi_channel_servo_pwm #(
    parameter int CHANNELS = 10
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // Input stream
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire [mcsp_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [3:0] channel, [11:4] angle
    input  wire                             s_axis_tuser,  // [0] func
    // Result stream
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [mcsp_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [9:0] pins, [19:10] phase
    // Configuration writes
    input  wire                             i_cfg_we,
    input  mcsp_pkg::t_cfg_addr             i_cfg_addr,
    input  wire [mcsp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mcsp_pkg::*;

    // Channels that can reach the pins field
    localparam int PIN_CH = (CHANNELS < PINS_W) ? CHANNELS : PINS_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0] r_period_top;
    logic [PULSE_W-1:0] r_pulse_min;
    logic [PULSE_W-1:0] r_pulse_max;
    logic [PINS_W-1:0]  r_ch_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_top <= PERIOD_TOP_RST;
            r_pulse_min  <= PULSE_MIN_RST;
            r_pulse_max  <= PULSE_MAX_RST;
            r_ch_enable  <= CH_ENABLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PERIOD_TOP: r_period_top <= i_cfg_data[PHASE_W-1:0];
                CFG_PULSE_MIN:  r_pulse_min  <= i_cfg_data[PULSE_W-1:0];
                CFG_PULSE_MAX:  r_pulse_max  <= i_cfg_data[PULSE_W-1:0];
                CFG_CH_ENABLE:  r_ch_enable  <= i_cfg_data[PINS_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // Each stage accepts when empty or when its contents move on, so bubbles
    // collapse; a held result stalls the input only once every stage is full.
    // ------------------------------------------------------------------
    logic r_a_valid;
    logic r_b_valid;
    logic r_out_valid;
    logic ready_out;
    logic ready_b;
    logic ready_a;
    logic in_xfer;
    logic retire;

    assign ready_out     = !r_out_valid || m_axis_tready;
    assign ready_b       = !r_b_valid || ready_out;
    assign ready_a       = !r_a_valid || ready_b;
    assign s_axis_tready = ready_a;
    assign in_xfer       = s_axis_tvalid && ready_a;
    assign retire        = r_b_valid && ready_out;   // item applies to state

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ready_a) begin
                r_a_valid <= s_axis_tvalid;
            end
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
            if (ready_out) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    // Carry the item kind and channel alongside the scaling stages
    logic [FUNC_W-1:0] r_a_func;
    logic [CHAN_W-1:0] r_a_chan;
    logic [FUNC_W-1:0] r_b_func;
    logic [CHAN_W-1:0] r_b_chan;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_func <= s_axis_tuser;
            r_a_chan <= s_axis_tdata[CHAN_W-1:0];
        end
        if (ready_b && r_a_valid) begin
            r_b_func <= r_a_func;
            r_b_chan <= r_a_chan;
        end
    end

    // ------------------------------------------------------------------
    // Angle to pulse width: product in stage A, divide and offset in stage B
    // ------------------------------------------------------------------
    t_scale_ctl         scale_ctl;
    logic [PULSE_W-1:0] b_width;

    assign scale_ctl.load_a = in_xfer;
    assign scale_ctl.load_b = ready_b && r_a_valid;

    mcsp_angle_scale u_scale (
        .i_clk       (i_clk),
        .i_ctl       (scale_ctl),
        .i_angle     (s_axis_tdata[CHAN_W +: ANGLE_W]),
        .i_pulse_min (r_pulse_min),
        .i_pulse_max (r_pulse_max),
        .o_width     (b_width)
    );

    // ------------------------------------------------------------------
    // State update at retirement
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0] r_period_count;
    logic [PULSE_W-1:0] r_pulse_width [CHANNELS];
    logic [PINS_W-1:0]  r_pin_levels;

    logic [PHASE_W:0]   count_inc;
    logic [PHASE_W-1:0] n_period_count;
    logic [PINS_W-1:0]  n_pin_levels;

    // Tick: advance, wrapping past the top (a top of zero holds the count at
    // zero); then drive each enabled pin high while below its pulse width.
    always_comb begin
        count_inc      = {1'b0, r_period_count} + (PHASE_W+1)'(1);
        n_period_count = (count_inc > {1'b0, r_period_top}) ? '0 : count_inc[PHASE_W-1:0];
        n_pin_levels   = '0;
        for (int n = 0; n < PIN_CH; n++) begin
            n_pin_levels[n] = r_ch_enable[n]
                && (n_period_count < PHASE_W'(r_pulse_width[n]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_count <= '0;
            r_pin_levels   <= '0;
            for (int n = 0; n < CHANNELS; n++) begin
                r_pulse_width[n] <= '0;
            end
        end else if (retire) begin
            unique case (r_b_func)
                FUNC_TICK: begin
                    r_period_count <= n_period_count;
                    r_pin_levels   <= n_pin_levels;
                end
                FUNC_ANGLE: begin
                    // Channels beyond the array match no entry and are dropped
                    for (int n = 0; n < CHANNELS; n++) begin
                        if (r_b_chan == CHAN_W'(n)) begin
                            r_pulse_width[n] <= b_width;
                        end
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register: levels and count after the retiring item
    // ------------------------------------------------------------------
    logic [PINS_W-1:0]  r_out_pins;
    logic [PHASE_W-1:0] r_out_phase;

    always_ff @(posedge i_clk) begin
        if (retire) begin
            if (r_b_func == FUNC_TICK) begin
                r_out_pins  <= n_pin_levels;
                r_out_phase <= n_period_count;
            end else begin
                r_out_pins  <= r_pin_levels;
                r_out_phase <= r_period_count;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W-PINS_W-PHASE_W)'(0), r_out_phase, r_out_pins};

endmodule

`default_nettype wire

FILE: sim/tb_multi_channel_servo_pwm.sv
`default_nettype none

module tb_multi_channel_servo_pwm;
    timeunit 1ns;
    timeprecision 1ps;

    import mcsp_pkg::*;

    localparam int N_CH        = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int STALL_AT    = 700;     // result count at which the sink backs off
    localparam int STALL_LEN   = 90;      // long enough to back the pipeline up to the input
    localparam int N_SETTINGS  = 10;
    localparam int N_FIXED     = 6;
    localparam int DRAIN_WAIT  = 6;       // margin after the last drain for stray results

    // One result: pins in the low bits, phase above, as on m_axis_tdata
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [PINS_W-1:0]  pins;
    } t_servo_out;

    // Directed stimulus row; typed rows carry their expected result
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [CHAN_W-1:0]  chan;
        logic [ANGLE_W-1:0] angle;
        logic               typed;
        logic [PINS_W-1:0]  pins;
        logic [PHASE_W-1:0] phase;
    } t_script_row;

    // One register setting and the random traffic that runs under it
    typedef struct packed {
        logic [PHASE_W-1:0] top;
        logic [PULSE_W-1:0] lo;
        logic [PULSE_W-1:0] hi;
        logic [PINS_W-1:0]  enable;
        logic [11:0]        items;
        logic               steady;
    } t_setting;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;   // [3:0] channel, [11:4] angle
    logic                   s_axis_tuser;   // [0] func
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;   // [9:0] pins, [19:10] phase
    logic                   i_cfg_we;
    t_cfg_addr              i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    multi_channel_servo_pwm #(
        .CHANNELS(N_CH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Servo state as the block should hold it
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0] cfg_top;
    logic [PULSE_W-1:0] cfg_min;
    logic [PULSE_W-1:0] cfg_max;
    logic [PINS_W-1:0]  cfg_enable;
    logic [PHASE_W-1:0] count_model;
    logic [PINS_W-1:0]  pins_model;
    logic [PULSE_W-1:0] width_model [N_CH];

    t_servo_out results_due [$];   // pin/phase results still owed by the block

    bit steady_run = 1'b0;         // suppress idling on both sides
    int mismatches = 0;
    int results_seen = 0;
    int n_ticks = 0;
    int n_writes = 0;
    int n_absent = 0;
    int n_wraps = 0;
    int n_settings = 0;
    int cycles = 0;

    function automatic void servo_reset();
        cfg_top     = PERIOD_TOP_RST;
        cfg_min     = PULSE_MIN_RST;
        cfg_max     = PULSE_MAX_RST;
        cfg_enable  = CH_ENABLE_RST;
        count_model = '0;
        pins_model  = '0;
        for (int n = 0; n < N_CH; n++) width_model[n] = '0;
    endfunction

    function automatic void servo_config(input t_cfg_addr addr, input logic [CFG_DATA_W-1:0] data);
        case (addr)
            CFG_PERIOD_TOP: cfg_top    = data[PHASE_W-1:0];
            CFG_PULSE_MIN:  cfg_min    = data[PULSE_W-1:0];
            CFG_PULSE_MAX:  cfg_max    = data[PULSE_W-1:0];
            CFG_CH_ENABLE:  cfg_enable = data[PINS_W-1:0];
            default: ;
        endcase
    endfunction

    // Map an angle onto min..max; saturate above full scale, clamp an inverted span to zero
    function automatic logic [PULSE_W-1:0] width_for(input logic [ANGLE_W-1:0] ang);
        int unsigned deg;
        int unsigned span;
        deg  = (ang > ANGLE_FULL) ? 32'(ANGLE_FULL) : 32'(ang);
        span = (cfg_max > cfg_min) ? 32'(cfg_max) - 32'(cfg_min) : 0;
        return PULSE_W'((deg * span) / 32'(ANGLE_FULL) + 32'(cfg_min));
    endfunction

    function automatic t_servo_out servo_advance(input logic [FUNC_W-1:0] func,
                                                 input logic [CHAN_W-1:0] chan,
                                                 input logic [ANGLE_W-1:0] ang);
        logic [PHASE_W:0] nxt;
        t_servo_out       res;
        if (func == FUNC_TICK) begin
            // Form count+1 one bit wider so a top of 1023 still wraps
            nxt = {1'b0, count_model} + (PHASE_W+1)'(1);
            if (nxt > {1'b0, cfg_top}) nxt = '0;
            count_model = nxt[PHASE_W-1:0];
            if (count_model == '0) n_wraps++;
            pins_model = '0;
            for (int n = 0; n < N_CH; n++) begin
                if (cfg_enable[n] && count_model < PHASE_W'(width_model[n]))
                    pins_model[n] = 1'b1;
            end
        end else if (int'(chan) < N_CH) begin
            // New width shows on the pins only from the next tick
            width_model[chan] = width_for(ang);
        end
        res.pins  = pins_model;
        res.phase = count_model;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus tables
    // ------------------------------------------------------------------
    // Reset settings: top 385, widths 0, min 11, max 48, all channels enabled.
    // Until the first tick nothing moves, so the opening rows are typed in.
    localparam int N_SCRIPT = 24;
    t_script_row script [N_SCRIPT] = '{
        '{FUNC_TICK,  4'd0,  8'd0,   1'b1, 10'h000, 10'd1},  // first tick, all widths zero
        '{FUNC_ANGLE, 4'd0,  8'd0,   1'b1, 10'h000, 10'd1},  // angle zero, pins unchanged
        '{FUNC_ANGLE, 4'd9,  8'd255, 1'b1, 10'h000, 10'd1},  // saturating angle, top channel
        '{FUNC_ANGLE, 4'd15, 8'd90,  1'b1, 10'h000, 10'd1},  // absent channel, ignored
        '{FUNC_ANGLE, 4'd10, 8'd180, 1'b1, 10'h000, 10'd1},  // first absent channel
        '{FUNC_TICK,  4'd0,  8'd0,   1'b0, 10'h000, 10'd0},
        '{FUNC_ANGLE, 4'd4,  8'd180, 1'b0, 10'h000, 10'd0},
        '{FUNC_ANGLE, 4'd5,  8'd90,  1'b0, 10'h000, 10'd0},
        '{FUNC_ANGLE, 4'd1,  8'd1,   1'b0, 10'h000, 10'd0},
        '{FUNC_ANGLE, 4'd2,  8'd181, 1'b0, 10'h000, 10'd0},
        '{FUNC_ANGLE, 4'd3,  8'd179, 1'b0, 10'h000, 10'd0},
        '{FUNC_ANGLE, 4'd6,  8'd85,  1'b0, 10'h000, 10'd0},
        '{FUNC_ANGLE, 4'd7,  8'd128, 1'b0, 10'h000, 10'd0},
        '{FUNC_ANGLE, 4'd8,  8'd45,  1'b0, 10'h000, 10'd0},
        '{FUNC_TICK,  4'd0,  8'd0,   1'b0, 10'h000, 10'd0},
        '{FUNC_TICK,  4'd15, 8'd255, 1'b0, 10'h000, 10'd0},  // tick ignores channel and angle
        '{FUNC_TICK,  4'd0,  8'd0,   1'b0, 10'h000, 10'd0},
        '{FUNC_TICK,  4'd0,  8'd0,   1'b0, 10'h000, 10'd0},
        '{FUNC_TICK,  4'd0,  8'd0,   1'b0, 10'h000, 10'd0},
        '{FUNC_TICK,  4'd0,  8'd0,   1'b0, 10'h000, 10'd0},
        '{FUNC_TICK,  4'd0,  8'd0,   1'b0, 10'h000, 10'd0},
        '{FUNC_TICK,  4'd0,  8'd0,   1'b0, 10'h000, 10'd0},
        '{FUNC_TICK,  4'd0,  8'd0,   1'b0, 10'h000, 10'd0},
        '{FUNC_TICK,  4'd0,  8'd0,   1'b0, 10'h000, 10'd0}
    };

    // Fixed settings, extremes first; random ones follow in the main loop
    t_setting plan [N_FIXED] = '{
        '{10'd1,    8'd0,   8'd255, 10'h3FF, 12'd150, 1'b0},  // shortest period, full span
        '{10'd1023, 8'd255, 8'd255, 10'h3FF, 12'd120, 1'b1},  // longest period, no idling
        '{10'd0,    8'd40,  8'd10,  10'h2AA, 12'd100, 1'b0},  // counter held, limits inverted
        '{10'd37,   8'd0,   8'd0,   10'h000, 12'd80,  1'b0},  // all channels off
        '{10'd300,  8'd11,  8'd48,  10'h155, 12'd200, 1'b0},  // pins fall inside the period
        '{10'd12,   8'd5,   8'd200, 10'h3FF, 12'd250, 1'b0}
    };

    t_cfg_addr reg_order [4] = '{CFG_PERIOD_TOP, CFG_PULSE_MIN, CFG_PULSE_MAX, CFG_CH_ENABLE};

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offer one item, hold it until the transfer, then log what it must return.
    // tvalid stays high after the transfer so back-to-back items need no re-raise.
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [CHAN_W-1:0] chan,
                             input logic [ANGLE_W-1:0] ang, input logic typed,
                             input t_servo_out typed_out);
        t_servo_out predicted;
        if (!steady_run && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(3) != 0);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {{(S_TDATA_W - CHAN_W - ANGLE_W){1'b0}}, ang, chan};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = servo_advance(func, chan, ang);
        results_due.push_back(typed ? typed_out : predicted);
        if (func == FUNC_TICK) n_ticks++;
        else begin
            n_writes++;
            if (int'(chan) >= N_CH) n_absent++;
        end
    endtask

    // Drop tvalid and hold until the block has returned everything owed
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_due.size() != 0);
    endtask

    // Write all four registers on consecutive edges; only call with the block idle
    task automatic apply_setting(input t_setting s);
        logic [CFG_DATA_W-1:0] wdata;
        for (int r = 0; r < 4; r++) begin
            case (reg_order[r])
                CFG_PERIOD_TOP: wdata = CFG_DATA_W'(s.top);
                CFG_PULSE_MIN:  wdata = CFG_DATA_W'(s.lo);
                CFG_PULSE_MAX:  wdata = CFG_DATA_W'(s.hi);
                default:        wdata = CFG_DATA_W'(s.enable);
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= reg_order[r];
            i_cfg_data <= wdata;
            @(posedge i_clk);
            servo_config(reg_order[r], wdata);
        end
        i_cfg_we <= 1'b0;
        steady_run = s.steady;
        n_settings++;
    endtask

    // Random item: mostly ticks, angle writes spread over all channels,
    // a share of them to absent channels and beyond full scale
    task automatic send_random();
        int unsigned        roll;
        logic [CHAN_W-1:0]  chan;
        logic [ANGLE_W-1:0] ang;
        roll = $urandom_range(99);
        chan = CHAN_W'($urandom_range(15));
        ang  = ANGLE_W'($urandom_range(255));
        if (roll < 68) begin
            send_item(FUNC_TICK, chan, ang, 1'b0, '0);
        end else begin
            if (roll >= 72) chan = CHAN_W'($urandom_range(N_CH - 1));
            if (roll >= 80) ang = ANGLE_W'($urandom_range(180));
            send_item(FUNC_ANGLE, chan, ang, 1'b0, '0);
        end
    endtask

    initial begin
        t_setting   s;
        t_servo_out typed_out;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_TICK;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= CFG_PERIOD_TOP;
        i_cfg_data    <= '0;
        servo_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under reset settings
        foreach (script[k]) begin
            typed_out.pins  = script[k].pins;
            typed_out.phase = script[k].phase;
            send_item(script[k].func, script[k].chan, script[k].angle, script[k].typed,
                      typed_out);
        end
        drain_results();

        // Random part, one register setting at a time
        for (int p = 0; p < N_SETTINGS; p++) begin
            if (p < N_FIXED) begin
                s = plan[p];
            end else begin
                s.top    = (p == N_SETTINGS - 1) ? PHASE_W'($urandom_range(1, 1023))
                                                 : PHASE_W'($urandom_range(1, 60));
                s.lo     = PULSE_W'($urandom_range(255));
                s.hi     = PULSE_W'($urandom_range(255));
                s.enable = PINS_W'($urandom_range(1023));
                s.items  = 12'd130;
                s.steady = 1'b0;
            end
            apply_setting(s);
            for (int k = 0; k < int'(s.items); k++) begin
                // Once, pause the input mid-setting until the output has caught up
                if (p == N_FIXED - 1 && k == 100) drain_results();
                send_random();
            end
            drain_results();
        end

        // Catch anything the block emits beyond what it owed
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d ticks (%0d counter wraps) and %0d angle writes",
                 n_ticks, n_wraps, n_writes);
        $display("(%0d to absent channels) under %0d register settings; %0d results checked",
                 n_absent, n_settings + 1, results_seen);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("multi_channel_servo_pwm regression: pass");
        end else begin
            $display("multi_channel_servo_pwm regression: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: random back-pressure, one long hold-off, field checks
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string field, input logic [PHASE_W-1:0] want,
                                 input logic [PHASE_W-1:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected 0x%03h, got 0x%03h", $time, field, want, got);
    endtask

    initial begin
        int         stall_left;
        t_servo_out want;
        t_servo_out got;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got.pins  = m_axis_tdata[PINS_W-1:0];
                got.phase = m_axis_tdata[PINS_W +: PHASE_W];
                results_seen++;
                if (results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected transfer, expected none, got pins 0x%03h phase %0d",
                             $time, got.pins, got.phase);
                end else begin
                    want = results_due.pop_front();
                    if (got.pins !== want.pins) flag_mismatch("pins", want.pins, got.pins);
                    if (got.phase !== want.phase) flag_mismatch("phase", want.phase, got.phase);
                end
                // Back off for a long stretch so the block fills and stalls its input
                if (results_seen == STALL_AT) stall_left = STALL_LEN;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady_run || ($urandom_range(99) >= 7);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time, results_due.size());
            $display("multi_channel_servo_pwm regression: fail");
            $finish;
        end
    end

endmodule

`default_nettype wire
